@@ sv/tto_pkg.sv @@
// Shared types and constants for the timeout timer pool.
`timescale 1ns / 1ps

package tto_pkg;

	// Default number of timer slots in the pool.
	localparam int TIMER_SLOTS_DEF = 32;
	// Width of a time value in microseconds.
	localparam int TIME_BITS = 32;
	// Width of a slot handle on the ports.
	localparam int SLOT_W = 5;
	localparam int SUBJECT_W = 32;
	localparam int TAG_W = 8;

	// Command codes of a request.
	typedef enum logic [1:0] {
		CMD_SCHEDULE = 2'd0,
		CMD_CANCEL   = 2'd1,
		CMD_TICK     = 2'd2
	} cmd_t;

	// Kinds of result.
	typedef enum logic [2:0] {
		KIND_SCHEDULED = 3'd0,
		KIND_POOL_FULL = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_EXPIRED   = 3'd3,
		KIND_TICK_DONE = 3'd4
	} kind_t;

	// One request as it arrives.
	typedef struct packed {
		logic [1:0]           command;
		logic [TIME_BITS-1:0] current_time;
		logic [TIME_BITS-1:0] delay;
		logic [SUBJECT_W-1:0] subject;
		logic [TAG_W-1:0]     callback_tag;
		logic [SLOT_W-1:0]    slot_handle;
	} request_t;

	// One result as it leaves.
	typedef struct packed {
		kind_t                kind;
		logic [SLOT_W-1:0]    slot;
		logic [SUBJECT_W-1:0] expired_subject;
		logic [TAG_W-1:0]     expired_tag;
		logic                 last;
	} result_t;

	// Contents of one timer slot, as held in a cell and passed along the ring.
	typedef struct packed {
		logic                 in_use;
		logic                 expired;
		logic [TIME_BITS:0]   deadline;
		logic [SUBJECT_W-1:0] subject;
		logic [TAG_W-1:0]     tag;
	} slot_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic shift;
		logic load;
		logic cancel;
	} cell_ctl_t;

endpackage

@@ sv/timeout_timer_pool.sv @@
// Top level of the timeout timer pool: a ring of timer cells and its sequencer.
//
//  channel   ports                              handshake
//  request   request, start, busy               taken when start & !busy
//  result    result, result_valid               one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_wdata                  written when cfg_we is high
//
// The result of a schedule or cancel shows in the next cycle.
// A tick holds busy while the slot ring turns once, one
// slot a cycle past the compare at its head, then the tick-done result follows.
// Reset clears all slots to free and the cached time to zero; no clearing pass.
// Results cannot be stalled, so each appears for exactly one cycle.
`timescale 1ns / 1ps

module timeout_timer_pool #(
	parameter int TIMER_SLOTS = tto_pkg::TIMER_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tto_pkg::request_t request,
	output logic              result_valid,
	output tto_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);

	localparam int IDX_W = $clog2(TIMER_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                           state_q;
	logic [IDX_W-1:0]                 step_q;
	logic [tto_pkg::TIME_BITS-1:0]    cached_q;
	logic                             use_cached_q;
	logic                             res_vld_q;
	tto_pkg::result_t                 res_q;

	tto_pkg::slot_t                   cell_q [TIMER_SLOTS];
	tto_pkg::slot_t                   cell_in [TIMER_SLOTS];
	tto_pkg::cell_ctl_t               cell_ctl [TIMER_SLOTS];
	tto_pkg::slot_t                   load_data;
	tto_pkg::slot_t                   head;
	tto_pkg::slot_t                   tail;
	logic [TIMER_SLOTS-1:0]           used;
	logic                             any_free;
	logic [IDX_W-1:0]                 free_idx;
	logic                             accept;
	logic                             sched_fire;
	logic                             cancel_fire;
	logic                             hit;
	logic [tto_pkg::TIME_BITS-1:0]    sched_start;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign sched_fire  = accept && (request.command == tto_pkg::CMD_SCHEDULE);
	assign cancel_fire = accept && (request.command == tto_pkg::CMD_CANCEL);

	// Lowest free slot, found from the in-use bits of all cells.
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// New slot contents for a schedule request.
	assign sched_start = use_cached_q ? cached_q : request.current_time;
	always_comb begin
		load_data.in_use   = 1'b1;
		load_data.expired  = 1'b0;
		load_data.deadline = {1'b0, sched_start} + {1'b0, request.delay};
		load_data.subject  = request.subject;
		load_data.tag      = request.callback_tag;
	end

	// Head of the ring: expiry test and freeing of expired slots.
	assign head = cell_q[0];
	assign hit  = head.in_use && !head.expired && (head.deadline < {1'b0, cached_q});
	always_comb begin
		tail = head;
		if (head.in_use && (head.expired || hit)) begin
			tail.in_use  = 1'b0;
			tail.expired = 1'b0;
		end
	end

	// The ring of cells; the head slot wraps round to the tail after checking.
	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		if (i == TIMER_SLOTS - 1) begin : g_tail
			assign cell_in[i] = tail;
		end else begin : g_mid
			assign cell_in[i] = cell_q[i+1];
		end

		assign used[i] = cell_q[i].in_use;
		assign cell_ctl[i].shift  = (state_q == ST_SCAN);
		assign cell_ctl[i].load   = sched_fire && any_free && (free_idx == IDX_W'(i));
		assign cell_ctl[i].cancel = cancel_fire && (32'(request.slot_handle) == i);

		tto_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl[i]),
			.load_data (load_data),
			.shift_in  (cell_in[i]),
			.slot_q    (cell_q[i])
		);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_cached_q <= 1'b1;
		end else if (cfg_we) begin
			use_cached_q <= cfg_wdata;
		end
	end

	// Sequencer: tick scan over the ring, cached time and step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			cached_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (request.command == tto_pkg::CMD_TICK)) begin
						state_q  <= ST_SCAN;
						step_q   <= '0;
						cached_q <= request.current_time;
					end
				end
				ST_SCAN: begin
					step_q <= step_q + IDX_W'(1);
					if (step_q == IDX_W'(TIMER_SLOTS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= sched_fire || cancel_fire
				|| ((state_q == ST_SCAN) && hit) || (state_q == ST_DONE);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		res_q.kind            <= tto_pkg::KIND_TICK_DONE;
		res_q.slot            <= '0;
		res_q.expired_subject <= '0;
		res_q.expired_tag     <= '0;
		res_q.last            <= 1'b1;
		if (state_q == ST_SCAN) begin
			res_q.kind            <= tto_pkg::KIND_EXPIRED;
			res_q.slot            <= tto_pkg::SLOT_W'(step_q);
			res_q.expired_subject <= head.subject;
			res_q.expired_tag     <= head.tag;
			res_q.last            <= 1'b0;
		end else if (sched_fire) begin
			if (any_free) begin
				res_q.kind <= tto_pkg::KIND_SCHEDULED;
				res_q.slot <= tto_pkg::SLOT_W'(free_idx);
			end else begin
				res_q.kind <= tto_pkg::KIND_POOL_FULL;
			end
		end else if (cancel_fire) begin
			res_q.kind <= tto_pkg::KIND_CANCELLED;
			res_q.slot <= request.slot_handle;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

@@ sv/tto_cell.sv @@
// One timer cell of the ring: holds a slot, loads, cancels or passes it on.
`timescale 1ns / 1ps

module tto_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tto_pkg::cell_ctl_t ctl,
	input  tto_pkg::slot_t     load_data,
	input  tto_pkg::slot_t     shift_in,
	output tto_pkg::slot_t     slot_q
);

	logic                          in_use_q;
	logic                          expired_q;
	logic [tto_pkg::TIME_BITS:0]   deadline_q;
	logic [tto_pkg::SUBJECT_W-1:0] subject_q;
	logic [tto_pkg::TAG_W-1:0]     tag_q;

	// Status bits are control state and are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= 1'b0;
			expired_q <= 1'b0;
		end else if (ctl.shift) begin
			in_use_q  <= shift_in.in_use;
			expired_q <= shift_in.expired;
		end else if (ctl.load) begin
			in_use_q  <= load_data.in_use;
			expired_q <= load_data.expired;
		end else if (ctl.cancel && in_use_q) begin
			expired_q <= 1'b1;
		end
	end

	// Timer payload is only read for slots in use, so it needs no reset.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			deadline_q <= shift_in.deadline;
			subject_q  <= shift_in.subject;
			tag_q      <= shift_in.tag;
		end else if (ctl.load) begin
			deadline_q <= load_data.deadline;
			subject_q  <= load_data.subject;
			tag_q      <= load_data.tag;
		end
	end

	// The held slot as seen by the neighbours and the sequencer.
	always_comb begin
		slot_q.in_use   = in_use_q;
		slot_q.expired  = expired_q;
		slot_q.deadline = deadline_q;
		slot_q.subject  = subject_q;
		slot_q.tag      = tag_q;
	end

endmodule

@@ sv/tto_checker.sv @@
// Port-level checks for the timeout timer pool, bound to the top level.
`timescale 1ns / 1ps

module tto_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input tto_pkg::request_t request,
	input logic              result_valid,
	input tto_pkg::result_t  result
);

	// Only expiry reports are followed by further results of the same request.
	a_not_last_is_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.kind == tto_pkg::KIND_EXPIRED)
		else $error("non-final result is not an expiry report");

	// A tick keeps the block busy for its scan.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.command == tto_pkg::CMD_TICK |=> busy)
		else $error("tick accepted but block not busy");

	// Schedule and cancel answer with a single final result in the next cycle.
	a_short_reply: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (request.command == tto_pkg::CMD_SCHEDULE
			|| request.command == tto_pkg::CMD_CANCEL)
		|=> result_valid && result.last)
		else $error("schedule or cancel without a final result");

	// Expiry reports appear only while a tick is under way.
	a_expiry_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == tto_pkg::KIND_EXPIRED |-> busy)
		else $error("expiry report outside a tick");

	// The tick-done result closes the tick and frees the request side.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == tto_pkg::KIND_TICK_DONE |-> !busy && $past(busy))
		else $error("tick done not at the end of a tick");

endmodule

bind timeout_timer_pool tto_checker u_tto_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.request      (request),
	.result_valid (result_valid),
	.result       (result)
);

@@ bench/timeout_timer_pool_tb.sv @@
// Self-checking testbench for the timeout timer pool: random and directed requests.
`timescale 1ns / 1ps

module timeout_timer_pool_tb;

	localparam int POOL_SLOTS = tto_pkg::TIMER_SLOTS_DEF;
	// Idle cycles allowed before a register write, enough for a full tick scan.
	localparam int SETTLE_CYCLES = POOL_SLOTS + 8;
	localparam int TAIL_CYCLES = POOL_SLOTS + 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;
	// Command code that the block must ignore.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// One entry of the stimulus queue: a request or a write of use_cached_time.
	typedef struct {
		bit                is_cfg;
		bit                cfg_bit;
		tto_pkg::request_t req;
	} pool_op_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	tto_pkg::request_t request = '0;
	logic              result_valid;
	tto_pkg::result_t  result;
	logic              cfg_we = 1'b0;
	logic              cfg_wdata = 1'b0;

	pool_op_t          op_queue[$];
	tto_pkg::result_t  awaited_results[$];
	bit          req_taken = 1'b0;
	int          idle_left = 0;
	int          calm_left = 0;
	int          settle_count = 0;
	int          cycle_count = 0;
	int          mismatch_count = 0;
	int          result_count = 0;
	logic [31:0] stim_clock = '0;

	// Predicted pool contents.
	bit          slot_taken[POOL_SLOTS];
	bit          slot_lapsed[POOL_SLOTS];
	logic [32:0] slot_deadline[POOL_SLOTS];
	logic [31:0] slot_subj[POOL_SLOTS];
	logic [7:0]  slot_cb_tag[POOL_SLOTS];
	logic [31:0] tick_time = '0;
	bit          use_tick_time = 1'b1;

	timeout_timer_pool u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Work out the results of one accepted request and update the predicted pool.
	function automatic void timer_pool_predict(tto_pkg::request_t r);
		tto_pkg::result_t res;
		logic [31:0]      origin;
		bit               placed;
		res = '0;
		res.last = 1'b1;
		placed = 1'b0;
		case (r.command)
			tto_pkg::CMD_SCHEDULE: begin
				origin = use_tick_time ? tick_time : r.current_time;
				for (int i = 0; i < POOL_SLOTS; i++) begin
					if (!placed && !slot_taken[i]) begin
						placed = 1'b1;
						slot_taken[i] = 1'b1;
						slot_lapsed[i] = 1'b0;
						slot_deadline[i] = {1'b0, origin} + {1'b0, r.delay};
						slot_subj[i] = r.subject;
						slot_cb_tag[i] = r.callback_tag;
						res.kind = tto_pkg::KIND_SCHEDULED;
						res.slot = i[4:0];
					end
				end
				if (!placed)
					res.kind = tto_pkg::KIND_POOL_FULL;
				awaited_results.push_back(res);
			end
			tto_pkg::CMD_CANCEL: begin
				if (slot_taken[r.slot_handle])
					slot_lapsed[r.slot_handle] = 1'b1;
				res.kind = tto_pkg::KIND_CANCELLED;
				res.slot = r.slot_handle;
				awaited_results.push_back(res);
			end
			tto_pkg::CMD_TICK: begin
				tick_time = r.current_time;
				// Report the newly lapsed slots in ascending order.
				for (int i = 0; i < POOL_SLOTS; i++) begin
					if (slot_taken[i] && !slot_lapsed[i]
						&& slot_deadline[i] < {1'b0, tick_time}) begin
						slot_lapsed[i] = 1'b1;
						res = '0;
						res.kind = tto_pkg::KIND_EXPIRED;
						res.slot = i[4:0];
						res.expired_subject = slot_subj[i];
						res.expired_tag = slot_cb_tag[i];
						awaited_results.push_back(res);
					end
				end
				// Free every lapsed slot, cancelled ones included.
				for (int i = 0; i < POOL_SLOTS; i++) begin
					if (slot_taken[i] && slot_lapsed[i]) begin
						slot_taken[i] = 1'b0;
						slot_lapsed[i] = 1'b0;
					end
				end
				res = '0;
				res.kind = tto_pkg::KIND_TICK_DONE;
				res.last = 1'b1;
				awaited_results.push_back(res);
			end
			default: begin
			end
		endcase
	endfunction

	// Count a mismatch, and describe it while the report budget lasts.
	function automatic void flag_mismatch(bit have_want, tto_pkg::result_t want,
		tto_pkg::result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			if (!have_want)
				$display("result %0d: none awaited, got kind %0d slot %0d subject %h tag %h last %b",
					result_count, got.kind, got.slot, got.expired_subject, got.expired_tag,
					got.last);
			else
				$display("result %0d: expected kind %0d slot %0d subject %h tag %h last %b, %s",
					result_count, want.kind, want.slot, want.expired_subject, want.expired_tag,
					want.last, $sformatf("got kind %0d slot %0d subject %h tag %h last %b",
					got.kind, got.slot, got.expired_subject, got.expired_tag, got.last));
		end
	endfunction

	// Gap before the next request: mostly short, a few long, with calm stretches.
	function automatic int pick_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm_left = $urandom_range(20, 40);
			return 0;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 0;
			5, 6, 7, 8: return $urandom_range(1, 3);
			default: return $urandom_range(8, 40);
		endcase
	endfunction

	function automatic tto_pkg::request_t sched_req(logic [31:0] now, logic [31:0] dly,
		logic [31:0] subj, logic [7:0] tag);
		tto_pkg::request_t r;
		r = '0;
		r.command = tto_pkg::CMD_SCHEDULE;
		r.current_time = now;
		r.delay = dly;
		r.subject = subj;
		r.callback_tag = tag;
		return r;
	endfunction

	function automatic tto_pkg::request_t cancel_req(logic [4:0] handle);
		tto_pkg::request_t r;
		r = '0;
		r.command = tto_pkg::CMD_CANCEL;
		r.slot_handle = handle;
		return r;
	endfunction

	function automatic tto_pkg::request_t tick_req(logic [31:0] now);
		tto_pkg::request_t r;
		r = '0;
		r.command = tto_pkg::CMD_TICK;
		r.current_time = now;
		return r;
	endfunction

	// Any request at all, the ignored command code among them.
	function automatic tto_pkg::request_t rand_noise();
		tto_pkg::request_t r;
		r.command = 2'($urandom_range(0, 3));
		r.current_time = $urandom;
		r.delay = $urandom;
		r.subject = $urandom;
		r.callback_tag = 8'($urandom_range(0, 255));
		r.slot_handle = 5'($urandom_range(0, 31));
		return r;
	endfunction

	// A schedule near the running stimulus clock, with short delays mostly.
	function automatic tto_pkg::request_t rand_sched();
		tto_pkg::request_t r;
		r = rand_noise();
		r.command = tto_pkg::CMD_SCHEDULE;
		if ($urandom_range(0, 7) != 0)
			r.current_time = stim_clock + $urandom_range(0, 50);
		case ($urandom_range(0, 15))
			0: r.delay = $urandom;
			1: r.delay = '1;
			2: r.delay = '0;
			default: r.delay = $urandom_range(0, 400);
		endcase
		return r;
	endfunction

	// Cancels favour the low slots, which are the ones handed out first.
	function automatic tto_pkg::request_t rand_cancel();
		tto_pkg::request_t r;
		r = rand_noise();
		r.command = tto_pkg::CMD_CANCEL;
		if ($urandom_range(0, 3) != 0)
			r.slot_handle = 5'($urandom_range(0, 7));
		return r;
	endfunction

	// A tick moves the stimulus clock on, now and then jumping anywhere.
	function automatic tto_pkg::request_t rand_tick();
		tto_pkg::request_t r;
		if ($urandom_range(0, 9) == 0)
			stim_clock = $urandom;
		else
			stim_clock = stim_clock + $urandom_range(0, 500);
		r = rand_noise();
		r.command = tto_pkg::CMD_TICK;
		r.current_time = stim_clock;
		return r;
	endfunction

	function automatic void push_req(tto_pkg::request_t r);
		pool_op_t op;
		op.is_cfg = 1'b0;
		op.cfg_bit = 1'b0;
		op.req = r;
		op_queue.push_back(op);
	endfunction

	function automatic void push_cfg(bit value);
		pool_op_t op;
		op.is_cfg = 1'b1;
		op.cfg_bit = value;
		op.req = '0;
		op_queue.push_back(op);
	endfunction

	// Mostly bursts of schedules and cancels closed by a tick, plus some noise.
	function automatic void add_random_phase(int quota);
		int added;
		int pick;
		int n;
		added = 0;
		while (added < quota) begin
			pick = $urandom_range(0, 19);
			if (pick < 10) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 8);
				repeat (n) begin
					push_req(rand_sched());
					added++;
					if ($urandom_range(0, 3) == 0) begin
						push_req(rand_cancel());
						added++;
					end
				end
				push_req(rand_tick());
				added++;
			end else if (pick < 14) begin
				push_req(rand_tick());
				added++;
			end else if (pick < 17) begin
				repeat ($urandom_range(1, 3)) begin
					push_req(rand_cancel());
					added++;
				end
			end else if (pick < 19) begin
				push_req(rand_noise());
				added++;
			end else begin
				push_req(rand_tick());
				push_req(tick_req(stim_clock));
				added += 2;
			end
		end
	endfunction

	// Request driver: changes inputs at the falling edge only.
	always @(negedge clk) begin : drive_requests
		pool_op_t op;
		if (arst_n) begin
			if (start && !req_taken) begin
				// Hold the request until the block takes it.
			end else if (cfg_we) begin
				cfg_we <= 1'b0;
				start <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (op_queue.size() == 0) begin
				start <= 1'b0;
			end else if (op_queue[0].is_cfg) begin
				// Write the register only once the block has been quiet for a while.
				start <= 1'b0;
				if (awaited_results.size() != 0 || busy || start) begin
					settle_count = 0;
				end else if (settle_count < SETTLE_CYCLES) begin
					settle_count++;
				end else begin
					op = op_queue.pop_front();
					cfg_we <= 1'b1;
					cfg_wdata <= op.cfg_bit;
					settle_count = 0;
				end
			end else begin
				op = op_queue.pop_front();
				start <= 1'b1;
				request <= op.req;
				idle_left = pick_gap();
			end
		end
	end

	// Monitor: samples at the rising edge, checks results and predicts new requests.
	always @(posedge clk) begin : watch_results
		tto_pkg::result_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout_timer_pool: mismatch");
				$finish;
			end else begin
				if (cfg_we)
					use_tick_time = cfg_wdata;
				if (result_valid) begin
					if (awaited_results.size() == 0) begin
						flag_mismatch(1'b0, '0, result);
					end else begin
						want = awaited_results.pop_front();
						if (result.kind !== want.kind || result.slot !== want.slot
							|| result.expired_subject !== want.expired_subject
							|| result.expired_tag !== want.expired_tag
							|| result.last !== want.last)
							flag_mismatch(1'b1, want, result);
					end
					result_count++;
				end
				req_taken = start && !busy;
				if (req_taken)
					timer_pool_predict(request);
			end
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin : run_stimulus
		for (int i = 0; i < POOL_SLOTS; i++) begin
			slot_taken[i] = 1'b0;
			slot_lapsed[i] = 1'b0;
			slot_deadline[i] = '0;
			slot_subj[i] = '0;
			slot_cb_tag[i] = '0;
		end

		// Directed part, start times from the last tick (the reset setting).
		push_req(tick_req(32'h0));
		push_req(sched_req(32'd123, 32'h0, 32'hFFFF_FFFF, 8'hFF));
		push_req(sched_req(32'h0, 32'hFFFF_FFFF, 32'h0, 8'h00));
		push_req(cancel_req(5'd31));
		// Deadline equal to the tick time does not expire; one above it does.
		push_req(tick_req(32'h0));
		push_req(tick_req(32'h1));
		// Cancel twice, then the tick frees the slot without reporting it.
		push_req(cancel_req(5'd1));
		push_req(cancel_req(5'd1));
		push_req(tick_req(32'hFFFF_FFFF));
		// Largest start plus largest delay must not wrap.
		push_req(sched_req(32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 8'h81));
		push_req(tick_req(32'hFFFF_FFFF));
		push_req(cancel_req(5'd0));
		push_req(tick_req(32'h0));
		push_req(rand_noise());
		op_queue[$].req.command = CMD_UNUSED;

		// Directed part with start times from the request itself.
		push_cfg(1'b0);
		push_req(sched_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'h5A));
		push_req(sched_req(32'h10, 32'h5, 32'h5A5A_5A5A, 8'hA5));
		push_req(tick_req(32'h15));
		push_req(tick_req(32'h16));
		push_req(cancel_req(5'd0));
		push_req(tick_req(32'h0));

		// Random part across both register settings.
		add_random_phase(102);
		push_cfg(1'b1);
		add_random_phase(102);
		push_cfg(1'b0);
		add_random_phase(102);
		push_cfg(1'b1);
		add_random_phase(102);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || start || cfg_we)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("timeout_timer_pool: match");
		else
			$display("timeout_timer_pool: mismatch");
		$finish;
	end

endmodule
